// ===== hw/rtl/tsbm_pkg.sv =====
// Package with the shared types, codes and constants of the two-wire sensor bus master.
package tsbm_pkg;

	// Width of the ready-wait counter.
	localparam int TIMER_WIDTH = 32;

	// Request codes carried on the op field.
	localparam logic [2:0] OP_TICK      = 3'd0;
	localparam logic [2:0] OP_SOFT_RST  = 3'd1;
	localparam logic [2:0] OP_RD_STATUS = 3'd2;
	localparam logic [2:0] OP_WR_STATUS = 3'd3;
	localparam logic [2:0] OP_MEASURE   = 3'd4;

	// Transaction status codes.
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NACK    = 2'd1;
	localparam logic [1:0] ST_TIMEOUT = 2'd2;

	// Configuration register indexes.
	localparam int CFG_INDEX_W = 3;
	localparam logic [CFG_INDEX_W-1:0] CFG_BIT_HALF  = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_SETUP     = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_TIMEOUT   = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_POLL      = 3'd3;

	// Reset values of the configuration registers.
	localparam logic [7:0]  BIT_HALF_RST = 8'd5;
	localparam logic [7:0]  SETUP_RST    = 8'd1;
	localparam logic [31:0] TIMEOUT_RST  = 32'd2000000;
	localparam logic [31:0] POLL_RST     = 32'd100000;

	// Number of clocks sent with data high during a soft reset.
	localparam logic [3:0] RST_CLOCKS = 4'd9;
	// Number of bits in a byte on the wire.
	localparam logic [3:0] BYTE_BITS  = 4'd8;

	// Line sequencer phases.
	typedef enum logic [4:0] {
		PH_IDLE, PH_RST_INIT, PH_RST_HI, PH_RST_LO,
		PH_S0, PH_S1, PH_S2, PH_S3, PH_S4, PH_S5, PH_S6,
		PH_W_HI, PH_W_LO, PH_W_REL, PH_W_AHI, PH_W_ALO,
		PH_R_HI, PH_R_LO, PH_R_ASET, PH_R_AHI, PH_R_ALO, PH_R_END,
		PH_POLL
	} phase_t;

	// Levels driven on the two bus lines.
	typedef struct packed {
		logic sck;
		logic drv;
		logic lvl;
	} line_t;

	// One result item.
	typedef struct packed {
		line_t       line;
		logic        busy;
		logic        done;
		logic [1:0]  status;
		logic [15:0] read_value;
		logic [7:0]  checksum;
		logic [31:0] ready_wait_ticks;
	} res_t;

	// Builds a line setting; a released data line always reads as level zero.
	function automatic line_t mk_line(input logic sck, input logic drv, input logic lvl);
		line_t l;
		l.sck = sck;
		l.drv = drv;
		l.lvl = drv & lvl;
		return l;
	endfunction

endpackage

// ===== hw/rtl/two_wire_sensor_bus_master_core.sv =====
// Top level of the two-wire sensor bus master: line sequencer and result buffering.
//
// Channel  Direction  Handshake              Payload
// in       input      in_valid / in_ready    op, command, write_value, data_in
// out      output     out_valid / out_ready  sck_level .. ready_wait_ticks
// cfg      input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Every accepted tick yields one result and advances the sequencer state,
// so a tick can be accepted every clock cycle while in_ready is high.
// The result is held in an output register backed by one skid register; in_ready
// drops only while both are full, i.e. after two results wait on a stalled output.
// Reset clears the sequencer to idle with the clock low and data released, and
// loads the configuration registers with their default values.
// Configuration writes are always accepted (cfg_ready is tied high).
module two_wire_sensor_bus_master_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [2:0]                        op,
	input  logic [7:0]                        command,
	input  logic [7:0]                        write_value,
	input  logic                              data_in,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              sck_level,
	output logic                              data_drive,
	output logic                              data_level,
	output logic                              busy_res,
	output logic                              done_res,
	output logic [1:0]                        status,
	output logic [15:0]                       read_value,
	output logic [7:0]                        checksum,
	output logic [31:0]                       ready_wait_ticks,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [tsbm_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [31:0]                       cfg_data
);
	import tsbm_pkg::*;

	// Configuration registers.
	logic [7:0]  bit_half_q;
	logic [7:0]  setup_q;
	logic [31:0] timeout_q;
	logic [31:0] poll_ival_q;

	// Sequencer state.
	phase_t                 phase_q, phase_d;
	logic [7:0]             delay_q, delay_d;
	logic [TIMER_WIDTH-1:0] wait_q, wait_d;
	logic [31:0]            poll_q, poll_d;
	logic [3:0]             bit_idx_q, bit_idx_d;
	logic [1:0]             byte_idx_q, byte_idx_d;
	logic [7:0]             shift_q, shift_d;
	logic [15:0]            value_q, value_d;
	logic [7:0]             csum_q, csum_d;
	logic [2:0]             kind_q, kind_d;
	logic [7:0]             cmd_q, cmd_d;
	logic [7:0]             wr_q, wr_d;
	line_t                  line_q, line_d;
	logic [1:0]             status_q, status_d;
	logic                   done_d;

	// Result buffering.
	res_t res_d;
	res_t out_q, skid_q;
	logic out_valid_q, skid_valid_q;

	logic in_acc, out_acc;
	logic [7:0] half_t, setup_t;
	logic [31:0] ival_t, poll_base;
	logic [3:0] bit_inc;
	logic last_rd;
	logic [TIMER_WIDTH-1:0] wait_max;
	logic [63:0] wait_ext;

	assign in_ready  = !skid_valid_q;
	assign in_acc    = in_valid && in_ready;
	assign out_acc   = out_valid_q && out_ready;
	assign cfg_ready = 1'b1;

	// Zero delays and a zero poll interval act as one tick.
	assign half_t   = (bit_half_q == 8'd0) ? 8'd1 : bit_half_q;
	assign setup_t  = (setup_q == 8'd0) ? 8'd1 : setup_q;
	assign ival_t   = (poll_ival_q == 32'd0) ? 32'd1 : poll_ival_q;
	assign wait_max = '1;
	assign bit_inc  = bit_idx_q + 4'd1;
	assign last_rd  = (kind_q == OP_RD_STATUS) ? (byte_idx_q >= 2'd1) : (byte_idx_q >= 2'd2);
	assign poll_base = (poll_q == 32'd0) ? ival_t : poll_q;

	// Configuration writes; indexes beyond the list are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_half_q  <= BIT_HALF_RST;
			setup_q     <= SETUP_RST;
			timeout_q   <= TIMEOUT_RST;
			poll_ival_q <= POLL_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_BIT_HALF: bit_half_q  <= cfg_data[7:0];
				CFG_SETUP:    setup_q     <= cfg_data[7:0];
				CFG_TIMEOUT:  timeout_q   <= cfg_data;
				CFG_POLL:     poll_ival_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Next state of the line sequencer for one tick.
	always_comb begin
		phase_d    = phase_q;
		delay_d    = delay_q;
		wait_d     = wait_q;
		poll_d     = poll_q;
		bit_idx_d  = bit_idx_q;
		byte_idx_d = byte_idx_q;
		shift_d    = shift_q;
		value_d    = value_q;
		csum_d     = csum_q;
		kind_d     = kind_q;
		cmd_d      = cmd_q;
		wr_d       = wr_q;
		line_d     = line_q;
		status_d   = status_q;
		done_d     = 1'b0;

		if (phase_q == PH_IDLE) begin
			// A request starts a transaction on the tick it arrives.
			if (op >= OP_SOFT_RST && op <= OP_MEASURE) begin
				kind_d     = op;
				cmd_d      = command;
				wr_d       = write_value;
				value_d    = 16'd0;
				csum_d     = 8'd0;
				status_d   = ST_OK;
				wait_d     = '0;
				byte_idx_d = 2'd0;
				line_d     = mk_line(1'b0, 1'b1, 1'b1);
				delay_d    = setup_t;
				phase_d    = (op == OP_SOFT_RST) ? PH_RST_INIT : PH_S0;
			end
		end else if (phase_q == PH_POLL) begin
			// Ready wait: sample the data line once per poll interval.
			if (poll_q == 32'd0 && !data_in) begin
				byte_idx_d = 2'd0;
				shift_d    = 8'd0;
				bit_idx_d  = 4'd0;
				phase_d    = PH_R_HI;
				line_d     = mk_line(1'b1, 1'b0, 1'b0);
				delay_d    = half_t;
			end else if (poll_q == 32'd0 &&
					(64'(wait_q) >= 64'(timeout_q) || wait_q == wait_max)) begin
				status_d   = ST_TIMEOUT;
				phase_d    = PH_IDLE;
				done_d     = 1'b1;
				line_d.sck = 1'b0;
			end else begin
				poll_d = poll_base - 32'd1;
				if (wait_q != wait_max) begin
					wait_d = wait_q + TIMER_WIDTH'(1);
				end
			end
		end else if (delay_q > 8'd1) begin
			delay_d = delay_q - 8'd1;
		end else begin
			// The current line setting has held long enough: take the next step.
			unique case (phase_q)
				PH_RST_INIT: begin
					bit_idx_d = 4'd0;
					phase_d   = PH_RST_HI;
					line_d    = mk_line(1'b1, 1'b1, 1'b1);
					delay_d   = setup_t;
				end
				PH_RST_HI: begin
					phase_d = PH_RST_LO;
					line_d  = mk_line(1'b0, 1'b1, 1'b1);
					delay_d = setup_t;
				end
				PH_RST_LO: begin
					bit_idx_d = bit_inc;
					phase_d   = (bit_inc < RST_CLOCKS) ? PH_RST_HI : PH_S0;
					line_d    = mk_line(bit_inc < RST_CLOCKS, 1'b1, 1'b1);
					delay_d   = setup_t;
				end
				PH_S0: begin
					phase_d = PH_S1;
					line_d  = mk_line(1'b1, 1'b1, 1'b1);
					delay_d = setup_t;
				end
				PH_S1: begin
					phase_d = PH_S2;
					line_d  = mk_line(1'b1, 1'b1, 1'b0);
					delay_d = setup_t;
				end
				PH_S2: begin
					phase_d = PH_S3;
					line_d  = mk_line(1'b0, 1'b1, 1'b0);
					delay_d = half_t;
				end
				PH_S3: begin
					phase_d = PH_S4;
					line_d  = mk_line(1'b1, 1'b1, 1'b0);
					delay_d = setup_t;
				end
				PH_S4: begin
					phase_d = PH_S5;
					line_d  = mk_line(1'b1, 1'b1, 1'b1);
					delay_d = setup_t;
				end
				PH_S5: begin
					phase_d = PH_S6;
					line_d  = mk_line(1'b0, 1'b1, 1'b1);
					delay_d = setup_t;
				end
				PH_S6: begin
					byte_idx_d = 2'd0;
					shift_d    = cmd_q;
					bit_idx_d  = 4'd0;
					phase_d    = PH_W_HI;
					line_d     = mk_line(1'b1, 1'b1, cmd_q[7]);
					delay_d    = half_t;
				end
				PH_W_HI: begin
					phase_d = PH_W_LO;
					line_d  = mk_line(1'b0, 1'b1, line_q.lvl);
					delay_d = half_t;
				end
				PH_W_LO: begin
					bit_idx_d = bit_inc;
					if (bit_inc < BYTE_BITS) begin
						shift_d = {shift_q[6:0], 1'b0};
						phase_d = PH_W_HI;
						line_d  = mk_line(1'b1, 1'b1, shift_q[6]);
						delay_d = half_t;
					end else begin
						phase_d = PH_W_REL;
						line_d  = mk_line(1'b0, 1'b0, 1'b0);
						delay_d = setup_t;
					end
				end
				PH_W_REL: begin
					phase_d = PH_W_AHI;
					line_d  = mk_line(1'b1, 1'b0, 1'b0);
					delay_d = half_t;
				end
				PH_W_AHI: begin
					// A high data line during the acknowledge clock is a missing acknowledge.
					if (data_in) begin
						status_d   = ST_NACK;
						phase_d    = PH_IDLE;
						done_d     = 1'b1;
						line_d.sck = 1'b0;
					end else begin
						phase_d = PH_W_ALO;
						line_d  = mk_line(1'b0, 1'b0, 1'b0);
						delay_d = half_t;
					end
				end
				PH_W_ALO: begin
					if (kind_q == OP_WR_STATUS && byte_idx_q == 2'd0) begin
						byte_idx_d = 2'd1;
						shift_d    = wr_q;
						bit_idx_d  = 4'd0;
						phase_d    = PH_W_HI;
						line_d     = mk_line(1'b1, 1'b1, wr_q[7]);
						delay_d    = half_t;
					end else if (kind_q == OP_RD_STATUS) begin
						byte_idx_d = 2'd0;
						shift_d    = 8'd0;
						bit_idx_d  = 4'd0;
						phase_d    = PH_R_HI;
						line_d     = mk_line(1'b1, 1'b0, 1'b0);
						delay_d    = half_t;
					end else if (kind_q == OP_MEASURE) begin
						wait_d  = '0;
						poll_d  = 32'd0;
						phase_d = PH_POLL;
						line_d  = mk_line(1'b0, 1'b0, 1'b0);
						delay_d = 8'd1;
					end else begin
						status_d = ST_OK;
						phase_d  = PH_IDLE;
						done_d   = 1'b1;
					end
				end
				PH_R_HI: begin
					shift_d = {shift_q[6:0], data_in};
					phase_d = PH_R_LO;
					line_d  = mk_line(1'b0, 1'b0, 1'b0);
					delay_d = half_t;
				end
				PH_R_LO: begin
					bit_idx_d = bit_inc;
					if (bit_inc < BYTE_BITS) begin
						phase_d = PH_R_HI;
						line_d  = mk_line(1'b1, 1'b0, 1'b0);
						delay_d = half_t;
					end else begin
						// Acknowledge with data low, or end with a nack on the last byte.
						phase_d = PH_R_ASET;
						line_d  = mk_line(1'b0, 1'b1, last_rd);
						delay_d = setup_t;
					end
				end
				PH_R_ASET: begin
					phase_d = PH_R_AHI;
					line_d  = mk_line(1'b1, 1'b1, line_q.lvl);
					delay_d = half_t;
				end
				PH_R_AHI: begin
					phase_d = PH_R_ALO;
					line_d  = mk_line(1'b0, 1'b1, line_q.lvl);
					delay_d = half_t;
				end
				PH_R_ALO: begin
					phase_d = PH_R_END;
					line_d  = mk_line(1'b0, 1'b1, 1'b1);
					delay_d = setup_t;
				end
				PH_R_END: begin
					// File the byte just read: value bytes first, checksum last.
					if (kind_q == OP_RD_STATUS) begin
						if (byte_idx_q == 2'd0) begin
							value_d = {8'd0, shift_q};
						end else begin
							csum_d = shift_q;
						end
					end else begin
						if (byte_idx_q == 2'd0) begin
							value_d = {shift_q, value_q[7:0]};
						end else if (byte_idx_q == 2'd1) begin
							value_d = {value_q[15:8], shift_q};
						end else begin
							csum_d = shift_q;
						end
					end
					if (last_rd) begin
						status_d = ST_OK;
						phase_d  = PH_IDLE;
						done_d   = 1'b1;
					end else begin
						byte_idx_d = byte_idx_q + 2'd1;
						shift_d    = 8'd0;
						bit_idx_d  = 4'd0;
						phase_d    = PH_R_HI;
						line_d     = mk_line(1'b1, 1'b0, 1'b0);
						delay_d    = half_t;
					end
				end
				default: begin
					phase_d = PH_IDLE;
				end
			endcase
		end
	end

	// Result item seen after this tick.
	always_comb begin
		wait_ext               = 64'(wait_d);
		res_d.line             = line_d;
		res_d.busy             = (phase_d != PH_IDLE);
		res_d.done             = done_d;
		res_d.status           = status_d;
		res_d.read_value       = value_d;
		res_d.checksum         = csum_d;
		res_d.ready_wait_ticks = (wait_ext > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : wait_ext[31:0];
	end

	// Sequencer state registers advance on each accepted tick.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			delay_q    <= 8'd0;
			wait_q     <= '0;
			poll_q     <= 32'd0;
			bit_idx_q  <= 4'd0;
			byte_idx_q <= 2'd0;
			shift_q    <= 8'd0;
			value_q    <= 16'd0;
			csum_q     <= 8'd0;
			kind_q     <= OP_TICK;
			cmd_q      <= 8'd0;
			wr_q       <= 8'd0;
			line_q     <= mk_line(1'b0, 1'b0, 1'b0);
			status_q   <= ST_OK;
		end else if (in_acc) begin
			phase_q    <= phase_d;
			delay_q    <= delay_d;
			wait_q     <= wait_d;
			poll_q     <= poll_d;
			bit_idx_q  <= bit_idx_d;
			byte_idx_q <= byte_idx_d;
			shift_q    <= shift_d;
			value_q    <= value_d;
			csum_q     <= csum_d;
			kind_q     <= kind_d;
			cmd_q      <= cmd_d;
			wr_q       <= wr_d;
			line_q     <= line_d;
			status_q   <= status_d;
		end
	end

	// Output register with one skid register behind it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (out_acc) begin
				if (skid_valid_q) begin
					skid_valid_q <= 1'b0;
				end else begin
					out_valid_q <= in_acc;
				end
			end else if (!out_valid_q) begin
				out_valid_q <= in_acc;
			end else if (in_acc) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	// Payload of the output and skid registers.
	always_ff @(posedge clk) begin
		if (out_acc) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (in_acc) begin
				out_q <= res_d;
			end
		end else if (!out_valid_q) begin
			if (in_acc) begin
				out_q <= res_d;
			end
		end else if (in_acc) begin
			skid_q <= res_d;
		end
	end

	assign out_valid        = out_valid_q;
	assign sck_level        = out_q.line.sck;
	assign data_drive       = out_q.line.drv;
	assign data_level       = out_q.line.lvl;
	assign busy_res         = out_q.busy;
	assign done_res         = out_q.done;
	assign status           = out_q.status;
	assign read_value       = out_q.read_value;
	assign checksum         = out_q.checksum;
	assign ready_wait_ticks = out_q.ready_wait_ticks;

`ifndef ASSERT_OFF
	// The skid register is only filled while the output register holds a result.
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid register full while output register empty");

	// A transaction end is never reported together with busy.
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(out_q.done && out_q.busy))
		else $error("done reported while busy");

	// A released data line never carries a high level.
	a_released_low: assert property (@(posedge clk) disable iff (!arst_n)
		!line_q.drv |-> !line_q.lvl)
		else $error("data level high while data released");

	// Leaving the sequencer idle state happens only on a tick with a request.
	a_start_on_request: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_IDLE && in_acc && (op == OP_TICK || op > OP_MEASURE))
		|=> phase_q == PH_IDLE)
		else $error("transaction started without a request");
`endif

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the two-wire sensor bus master core.
`timescale 1ns / 1ps

module tb_top;
	import tsbm_pkg::*;

	localparam int QUIET_LIMIT = 500;
	localparam int SETTLE_CYCLES = 8;
	localparam int RANDOM_PHASES = 5;
	localparam int REQUESTS_PER_PHASE = 1;
	localparam bit [63:0] WAIT_LIMIT = (64'd1 << TIMER_WIDTH) - 64'd1;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   in_valid = 1'b0;
	logic                   in_ready;
	logic [2:0]             op = OP_TICK;
	logic [7:0]             command = 8'h00;
	logic [7:0]             write_value = 8'h00;
	logic                   data_in = 1'b1;
	logic                   out_valid;
	logic                   out_ready = 1'b0;
	logic                   sck_level;
	logic                   data_drive;
	logic                   data_level;
	logic                   busy_res;
	logic                   done_res;
	logic [1:0]             status;
	logic [15:0]            read_value;
	logic [7:0]             checksum;
	logic [31:0]            ready_wait_ticks;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = CFG_BIT_HALF;
	logic [31:0]            cfg_data = 32'd0;

	two_wire_sensor_bus_master_core DUT (.*);

	// Free-running clock.
	initial begin
		forever #5 clk = ~clk;
	end

	// Expected bus states, one per accepted tick, oldest first.
	res_t bus_outputs_q[$];
	int   mismatches = 0;
	int   results_seen = 0;
	int   out_stall = 0;
	bit   result_taken = 1'b0;
	int   quiet_cycles = 0;

	// Behavior of the simulated sensor and of the traffic pacing.
	bit          calm = 1'b1;
	bit          hurry = 1'b0;
	int          nack_byte = -1;
	int unsigned polls_until_ready = 0;

	// Predicted sequencer state and configuration.
	phase_t    seq_phase;
	bit [7:0]  seq_delay;
	bit [63:0] seq_wait;
	bit [31:0] seq_poll;
	bit [3:0]  seq_bit;
	bit [1:0]  seq_byte;
	bit [7:0]  seq_shift;
	bit [15:0] seq_value;
	bit [7:0]  seq_checksum;
	bit [2:0]  seq_kind;
	bit [7:0]  seq_command;
	bit [7:0]  seq_write;
	bit        seq_sck, seq_drv, seq_lvl;
	bit [1:0]  seq_status;
	bit        seq_done;
	bit [7:0]  reg_bit_half, reg_setup;
	bit [31:0] reg_timeout, reg_poll;

	function automatic void clear_sequencer();
		reg_bit_half = BIT_HALF_RST;
		reg_setup = SETUP_RST;
		reg_timeout = TIMEOUT_RST;
		reg_poll = POLL_RST;
		seq_phase = PH_IDLE;
		seq_delay = 0;
		seq_wait = 0;
		seq_poll = 0;
		seq_bit = 0;
		seq_byte = 0;
		seq_shift = 0;
		seq_value = 0;
		seq_checksum = 0;
		seq_kind = OP_TICK;
		seq_command = 0;
		seq_write = 0;
		seq_sck = 1'b0;
		seq_drv = 1'b0;
		seq_lvl = 1'b0;
		seq_status = ST_OK;
		seq_done = 1'b0;
	endfunction

	function automatic void apply_reg(bit [CFG_INDEX_W-1:0] idx, bit [31:0] data);
		case (idx)
			CFG_BIT_HALF: reg_bit_half = data[7:0];
			CFG_SETUP: reg_setup = data[7:0];
			CFG_TIMEOUT: reg_timeout = data;
			CFG_POLL: reg_poll = data;
			default: ;
		endcase
	endfunction

	// A delay register of zero behaves as one.
	function automatic bit [7:0] half_ticks();
		return (reg_bit_half != 0) ? reg_bit_half : 8'd1;
	endfunction

	function automatic bit [7:0] setup_delay();
		return (reg_setup != 0) ? reg_setup : 8'd1;
	endfunction

	function automatic void drive_lines(phase_t nxt, bit sck, bit drv, bit lvl, bit [7:0] ticks);
		seq_phase = nxt;
		seq_sck = sck;
		seq_drv = drv;
		seq_lvl = drv & lvl;
		seq_delay = ticks;
	endfunction

	// Errors pull the clock low; a good end leaves the lines alone.
	function automatic void end_transfer(bit [1:0] st);
		seq_status = st;
		seq_phase = PH_IDLE;
		seq_done = 1'b1;
		if (st != ST_OK) seq_sck = 1'b0;
	endfunction

	function automatic void start_byte_out(bit [7:0] b);
		seq_shift = b;
		seq_bit = 0;
		drive_lines(PH_W_HI, 1'b1, 1'b1, b[7], half_ticks());
	endfunction

	function automatic void start_byte_in();
		seq_shift = 0;
		seq_bit = 0;
		drive_lines(PH_R_HI, 1'b1, 1'b0, 1'b0, half_ticks());
	endfunction

	// The last byte read is answered with a nack instead of an ack.
	function automatic bit last_byte_in();
		return (seq_kind == OP_RD_STATUS) ? (seq_byte >= 1) : (seq_byte >= 2);
	endfunction

	function automatic void next_after_ack();
		if (seq_kind == OP_WR_STATUS && seq_byte == 0) begin
			seq_byte = 1;
			start_byte_out(seq_write);
		end else if (seq_kind == OP_RD_STATUS) begin
			seq_byte = 0;
			start_byte_in();
		end else if (seq_kind == OP_MEASURE) begin
			seq_wait = 0;
			seq_poll = 0;
			drive_lines(PH_POLL, 1'b0, 1'b0, 1'b0, 8'd1);
		end else begin
			end_transfer(ST_OK);
		end
	endfunction

	function automatic void store_byte_in();
		if (seq_kind == OP_RD_STATUS) begin
			if (seq_byte == 0) seq_value = {8'h00, seq_shift};
			else seq_checksum = seq_shift;
		end else if (seq_byte == 0) begin
			seq_value[15:8] = seq_shift;
		end else if (seq_byte == 1) begin
			seq_value[7:0] = seq_shift;
		end else begin
			seq_checksum = seq_shift;
		end
	endfunction

	// Ready wait: the data line is looked at once per poll interval.
	function automatic void sample_ready(bit din);
		if (seq_poll == 0) begin
			if (!din) begin
				seq_byte = 0;
				start_byte_in();
				return;
			end
			if (seq_wait >= reg_timeout || seq_wait >= WAIT_LIMIT) begin
				end_transfer(ST_TIMEOUT);
				return;
			end
			seq_poll = (reg_poll != 0) ? reg_poll : 32'd1;
		end
		seq_poll--;
		if (seq_wait < WAIT_LIMIT) seq_wait++;
	endfunction

	// Action at the end of a delay in each phase.
	function automatic void advance_phase(bit din);
		case (seq_phase)
			PH_RST_INIT: begin
				seq_bit = 0;
				drive_lines(PH_RST_HI, 1'b1, 1'b1, 1'b1, setup_delay());
			end
			PH_RST_HI: drive_lines(PH_RST_LO, 1'b0, 1'b1, 1'b1, setup_delay());
			PH_RST_LO: begin
				seq_bit++;
				if (seq_bit < RST_CLOCKS) drive_lines(PH_RST_HI, 1'b1, 1'b1, 1'b1, setup_delay());
				else drive_lines(PH_S0, 1'b0, 1'b1, 1'b1, setup_delay());
			end
			PH_S0: drive_lines(PH_S1, 1'b1, 1'b1, 1'b1, setup_delay());
			PH_S1: drive_lines(PH_S2, 1'b1, 1'b1, 1'b0, setup_delay());
			PH_S2: drive_lines(PH_S3, 1'b0, 1'b1, 1'b0, half_ticks());
			PH_S3: drive_lines(PH_S4, 1'b1, 1'b1, 1'b0, setup_delay());
			PH_S4: drive_lines(PH_S5, 1'b1, 1'b1, 1'b1, setup_delay());
			PH_S5: drive_lines(PH_S6, 1'b0, 1'b1, 1'b1, setup_delay());
			PH_S6: begin
				seq_byte = 0;
				start_byte_out(seq_command);
			end
			PH_W_HI: drive_lines(PH_W_LO, 1'b0, 1'b1, seq_lvl, half_ticks());
			PH_W_LO: begin
				seq_bit++;
				if (seq_bit < BYTE_BITS) begin
					seq_shift = seq_shift << 1;
					drive_lines(PH_W_HI, 1'b1, 1'b1, seq_shift[7], half_ticks());
				end else begin
					drive_lines(PH_W_REL, 1'b0, 1'b0, 1'b0, setup_delay());
				end
			end
			PH_W_REL: drive_lines(PH_W_AHI, 1'b1, 1'b0, 1'b0, half_ticks());
			PH_W_AHI: begin
				if (din) end_transfer(ST_NACK);
				else drive_lines(PH_W_ALO, 1'b0, 1'b0, 1'b0, half_ticks());
			end
			PH_W_ALO: next_after_ack();
			PH_R_HI: begin
				seq_shift = {seq_shift[6:0], din};
				drive_lines(PH_R_LO, 1'b0, 1'b0, 1'b0, half_ticks());
			end
			PH_R_LO: begin
				seq_bit++;
				if (seq_bit < BYTE_BITS) drive_lines(PH_R_HI, 1'b1, 1'b0, 1'b0, half_ticks());
				else drive_lines(PH_R_ASET, 1'b0, 1'b1, last_byte_in(), setup_delay());
			end
			PH_R_ASET: drive_lines(PH_R_AHI, 1'b1, 1'b1, seq_lvl, half_ticks());
			PH_R_AHI: drive_lines(PH_R_ALO, 1'b0, 1'b1, seq_lvl, half_ticks());
			PH_R_ALO: drive_lines(PH_R_END, 1'b0, 1'b1, 1'b1, setup_delay());
			PH_R_END: begin
				store_byte_in();
				if (last_byte_in()) begin
					end_transfer(ST_OK);
				end else begin
					seq_byte++;
					start_byte_in();
				end
			end
			default: seq_phase = PH_IDLE;
		endcase
	endfunction

	// Advances the predicted sequencer by one tick and returns the bus state it shows.
	function automatic res_t predict_bus_tick(bit [2:0] req, bit [7:0] cmd, bit [7:0] val, bit din);
		res_t r;
		seq_done = 1'b0;
		if (seq_phase == PH_IDLE) begin
			if (req >= OP_SOFT_RST && req <= OP_MEASURE) begin
				seq_kind = req;
				seq_command = cmd;
				seq_write = val;
				seq_value = 0;
				seq_checksum = 0;
				seq_status = ST_OK;
				seq_wait = 0;
				seq_byte = 0;
				if (req == OP_SOFT_RST) drive_lines(PH_RST_INIT, 1'b0, 1'b1, 1'b1, setup_delay());
				else drive_lines(PH_S0, 1'b0, 1'b1, 1'b1, setup_delay());
			end
		end else if (seq_phase == PH_POLL) begin
			sample_ready(din);
		end else if (seq_delay > 1) begin
			seq_delay--;
		end else begin
			advance_phase(din);
		end
		r.line.sck = seq_sck;
		r.line.drv = seq_drv;
		r.line.lvl = seq_drv & seq_lvl;
		r.busy = (seq_phase != PH_IDLE);
		r.done = seq_done;
		r.status = seq_status;
		r.read_value = seq_value;
		r.checksum = seq_checksum;
		r.ready_wait_ticks = (seq_wait > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : seq_wait[31:0];
		return r;
	endfunction

	// Data line level that the sensor presents on the next tick.
	function automatic bit sensor_level();
		if (seq_phase == PH_POLL && seq_poll == 0) begin
			if (polls_until_ready == 0) return 1'b0;
			polls_until_ready--;
			return 1'b1;
		end
		if (seq_phase == PH_W_AHI && seq_delay <= 1) return (nack_byte == int'(seq_byte));
		return 1'($urandom_range(1));
	endfunction

	function automatic void check_field(string name, bit [31:0] want, logic [31:0] got);
		if (got !== want) begin
			mismatches++;
			if (mismatches <= 10)
				$display("result %0d: %s expected 0x%0h, got 0x%0h", results_seen, name, want, got);
		end
	endfunction

	// Sends one tick and records its expected bus state once it is accepted.
	task automatic send_tick(input bit [2:0] req, input bit [7:0] cmd, input bit [7:0] val,
			input bit din);
		int gap;
		gap = calm ? 0 : $urandom_range(11);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		op <= req;
		command <= cmd;
		write_value <= val;
		data_in <= din;
		do @(posedge clk); while (!in_ready);
		bus_outputs_q.push_back(predict_bus_tick(req, cmd, val, din));
	endtask

	// Idle ticks with codes that start nothing.
	task automatic idle_ticks(input int count);
		bit [2:0] code;
		repeat (count) begin
			code = $urandom_range(1) ? OP_TICK : 3'(OP_MEASURE + $urandom_range(1, 3));
			send_tick(code, 8'($urandom_range(255)), 8'($urandom_range(255)),
				1'($urandom_range(1)));
		end
	endtask

	// Issues one request and keeps ticking until the sequencer is idle again.
	task automatic run_transaction(input bit [2:0] req, input bit [7:0] cmd, input bit [7:0] val);
		calm = hurry || ($urandom_range(2) != 0);
		send_tick(req, cmd, val, 1'($urandom_range(1)));
		while (seq_phase != PH_IDLE)
			send_tick(3'($urandom_range(7)), 8'($urandom_range(255)), 8'($urandom_range(255)),
				sensor_level());
	endtask

	// Holds the input off until every expected bus state has come out.
	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (bus_outputs_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input bit [CFG_INDEX_W-1:0] idx, input bit [31:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		apply_reg(idx, data);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic configure(input bit [7:0] half, input bit [7:0] setup, input bit [31:0] timeout,
			input bit [31:0] poll);
		drain_results();
		write_reg(CFG_BIT_HALF, 32'(half));
		write_reg(CFG_SETUP, 32'(setup));
		write_reg(CFG_TIMEOUT, timeout);
		write_reg(CFG_POLL, poll);
	endtask

	task automatic test_ignored_ops();
		calm = 1'b0;
		send_tick(OP_TICK, 8'hFF, 8'hFF, 1'b1);
		idle_ticks(3);
		send_tick(OP_MEASURE + 3'd1, 8'h00, 8'h00, 1'b0);
		send_tick(OP_MEASURE + 3'd3, 8'hFF, 8'hFF, 1'b1);
	endtask

	// Runs on the bit timing that reset leaves in the registers.
	task automatic test_soft_reset();
		run_transaction(OP_SOFT_RST, 8'hFF, 8'h00);
	endtask

	// The fastest bit timing keeps these transactions short.
	task automatic test_read_status();
		configure(8'd1, 8'd1, TIMEOUT_RST, POLL_RST);
		run_transaction(OP_RD_STATUS, 8'h07, 8'hFF);
	endtask

	task automatic test_write_status();
		run_transaction(OP_WR_STATUS, 8'h06, 8'hA5);
	endtask

	// Default timers: the sensor is ready at the first look.
	task automatic test_measure();
		polls_until_ready = 0;
		run_transaction(OP_MEASURE, 8'h03, 8'h5A);
	endtask

	task automatic test_missing_ack();
		nack_byte = 0;
		run_transaction(OP_MEASURE, 8'h03, 8'h00);
		run_transaction(OP_RD_STATUS, 8'h07, 8'h00);
		nack_byte = 1;
		run_transaction(OP_WR_STATUS, 8'h06, 8'h01);
		nack_byte = -1;
	endtask

	// Ready wait with a zero poll interval, with a timeout, and with a counted wait.
	task automatic test_ready_wait();
		configure(8'd1, 8'd1, 32'd1, 32'd0);
		polls_until_ready = '1;
		run_transaction(OP_MEASURE, 8'h03, 8'h00);
		configure(8'd1, 8'd1, 32'd40, 32'd3);
		polls_until_ready = 4;
		run_transaction(OP_MEASURE, 8'h05, 8'h00);
		polls_until_ready = '1;
		run_transaction(OP_MEASURE, 8'h03, 8'h00);
	endtask

	// Writes to indexes past the register list must change nothing.
	task automatic test_unused_index();
		drain_results();
		for (int k = 1; k <= 4; k++)
			write_reg(CFG_INDEX_W'(int'(CFG_POLL) + k), $urandom_range(255));
		polls_until_ready = 2;
		run_transaction(OP_MEASURE, 8'h03, 8'h00);
	endtask

	task automatic test_zero_delays();
		configure(8'd0, 8'd0, 32'd40, 32'd2);
		run_transaction(OP_SOFT_RST, 8'hFF, 8'h00);
		polls_until_ready = 2;
		run_transaction(OP_MEASURE, 8'h05, 8'h00);
	endtask

	// Setup delays longer than the bit halves; the command is refused to keep it short.
	task automatic test_slow_lines();
		configure(8'd2, 8'd4, 32'd40, 32'd2);
		hurry = 1'b1;
		nack_byte = 0;
		run_transaction(OP_WR_STATUS, 8'hAA, 8'h55);
		nack_byte = -1;
		hurry = 1'b0;
	endtask

	task automatic test_long_timers();
		configure(8'd1, 8'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		polls_until_ready = 0;
		run_transaction(OP_MEASURE, 8'h03, 8'h00);
	endtask

	// Mostly complete transactions with random content; some refused or timed out.
	task automatic test_random_traffic();
		bit [2:0] req;
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			case (p)
				0: configure(8'd1, 8'd1, 32'd30, 32'd1);
				1: configure(8'd1, 8'd2, 32'd12, 32'd2);
				2: configure(8'd1, 8'd3, 32'd100, 32'd0);
				3: configure(8'($urandom_range(1, 2)), 8'($urandom_range(1, 2)),
						$urandom_range(1, 60), $urandom_range(5));
				default: configure(8'd1, 8'd2, 32'hFFFF_FFFF, 32'd4);
			endcase
			repeat (REQUESTS_PER_PHASE) begin
				if ($urandom_range(4) == 0) idle_ticks($urandom_range(1, 3));
				if ($urandom_range(49) == 0) drain_results();
				req = 3'($urandom_range(OP_SOFT_RST, OP_MEASURE));
				nack_byte = ($urandom_range(9) == 0) ? int'($urandom_range(1)) : -1;
				if ($urandom_range(9) == 0 && reg_timeout <= 1000) polls_until_ready = '1;
				else polls_until_ready = $urandom_range(6);
				run_transaction(req, 8'($urandom_range(255)), 8'($urandom_range(255)));
			end
		end
		nack_byte = -1;
	endtask

	// Output side: a random stall after each result unless the traffic is calm.
	always @(negedge clk) begin
		if (result_taken) out_stall = calm ? 0 : $urandom_range(11);
		if (out_stall > 0) begin
			out_ready <= 1'b0;
			out_stall--;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Compare each result with the oldest expected bus state.
	always @(posedge clk) begin
		res_t want;
		result_taken = arst_n && out_valid && out_ready;
		if (arst_n && out_valid && out_ready) begin
			if (bus_outputs_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("result %0d arrived with none expected", results_seen);
			end else begin
				want = bus_outputs_q.pop_front();
				check_field("sck_level", 32'(want.line.sck), 32'(sck_level));
				check_field("data_drive", 32'(want.line.drv), 32'(data_drive));
				check_field("data_level", 32'(want.line.lvl), 32'(data_level));
				check_field("busy_res", 32'(want.busy), 32'(busy_res));
				check_field("done_res", 32'(want.done), 32'(done_res));
				check_field("status", 32'(want.status), 32'(status));
				check_field("read_value", 32'(want.read_value), 32'(read_value));
				check_field("checksum", 32'(want.checksum), 32'(checksum));
				check_field("ready_wait_ticks", want.ready_wait_ticks, ready_wait_ticks);
			end
			results_seen++;
		end
	end

	// Watchdog on cycles without any transaction.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		clear_sequencer();
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_ignored_ops();
		test_soft_reset();
		test_read_status();
		test_write_status();
		test_measure();
		test_missing_ack();
		test_ready_wait();
		test_unused_index();
		test_zero_delays();
		test_slow_lines();
		test_long_timers();
		test_random_traffic();
		drain_results();
		if (mismatches == 0) $display("PASS");
		else $display("FAIL");
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/tsbm_pkg.sv
hw/rtl/two_wire_sensor_bus_master_core.sv
tb/tb_top.sv
